@@ rtl/core/cwl_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the credential whitelist with lockout unit
// no dependencies; used by the top level, the card store and the checker by scoped names

package cwl_pkg;

  // whitelist geometry
  localparam int MAX_CARDS = 16;
  localparam int IDX_W     = $clog2(MAX_CARDS);
  localparam int CNT_W     = $clog2(MAX_CARDS + 1);

  // pin format: top PIN_CHARS bytes of a 32-bit word take part
  localparam int PIN_CHARS = 4;
  localparam int LEN_W     = 4;
  localparam logic [31:0] PIN_MASK  = 32'hFFFF_FFFF << (8 * (4 - PIN_CHARS));
  localparam logic [31:0] PIN_RESET = 32'h3132_3334;

  // configuration reset values
  localparam logic [7:0]  FAIL_LIMIT_RESET = 8'd5;
  localparam logic [31:0] BASE_MS_RESET    = 32'd30000;
  localparam logic [31:0] MAX_MS_RESET     = 32'd300000;
  localparam logic [7:0]  LEVEL_MAX        = 8'hFF;

  // stream widths
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 40;
  localparam int KIND_W     = 3;

  typedef enum logic [KIND_W-1:0] {
    REQ_CHECK  = 3'd0,
    REQ_ADD    = 3'd1,
    REQ_VERIFY = 3'd2,
    REQ_SETPIN = 3'd3,
    REQ_FAIL   = 3'd4,
    REQ_CLEAR  = 3'd5,
    REQ_QUERY  = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    CFG_FAIL_LIMIT = 2'd0,
    CFG_BASE_MS    = 2'd1,
    CFG_MAX_MS     = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_FAIL,
    ST_LOCK_WAIT,
    ST_LOCK_SET,
    ST_RESP
  } state_t;

  // card store port group
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [31:0]      wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

@@ rtl/core/credential_whitelist_with_lockout_unit.sv @@
`timescale 1ns / 1ps
// top level of the access guard: card whitelist, pin check, failure lockout
// depends on cwl_pkg, cwl_card_mem and cwl_lock_calc
//
//  port group  | dir | contents
//  ------------+-----+-----------------------------------------------------
//  s_t*        | in  | one request: tuser kind, tdata card, pins, lengths, time
//  m_t*        | out | one response per request: ok, locked, remaining, count
//  cfg_*       | in  | register writes: fail limit, base and max lock time
//
// a card check, or an add to a table that is not full, scans the stored
// cards one per cycle through the card store read port, stopping on a hit
// pin, clear, query: exec, resp; a lockout: fail, lock wait, lock set, resp
// one request at a time; a new request is taken while the last response waits
// reset is synchronous; it clears the card count, streak, level and deadline,
// restores the pin and registers; the card store itself is not cleared (entries
// past the count are never read); a stalled response holds and blocks the next
// completion

module credential_whitelist_with_lockout_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // card_id, pin_entry, pin_entry_length, replacement_pin,
  // replacement_pin_length, now_ms
  input  logic [cwl_pkg::IN_DATA_W-1:0]  s_tdata,
  // req_type
  input  logic [cwl_pkg::KIND_W-1:0]     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // ok, locked, time left, card_count, one zero pad bit
  output logic [cwl_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [31:0]                    cfg_data
);

  cwl_pkg::state_t   state, state_next;
  cwl_pkg::req_t     req;
  cwl_pkg::mem_req_t mem_req;

  // captured request
  logic [31:0]              card_id, pin_entry, new_pin, now_ms;
  logic [cwl_pkg::LEN_W-1:0] pin_len, new_pin_len;

  // configuration
  logic [7:0]  fail_limit;
  logic [31:0] base_ms, max_ms;

  // guard state
  logic [cwl_pkg::CNT_W-1:0] card_count;
  logic [31:0]               stored_pin;
  logic [7:0]                miss_run, lock_level, lock_level_next;
  logic [31:0]               deadline;

  // scan control
  logic [cwl_pkg::CNT_W-1:0] scan_idx;
  logic                      rd_pend;
  logic [31:0]               rd_data;
  logic                      hit, scan_end;

  // result being built
  logic        res_ok, res_locked;
  logic [31:0] res_rem;

  logic        out_free, pin_ok, streak_trig, table_full;
  logic [7:0]  streak_inc;
  logic [31:0] lock_ms;
  cwl_pkg::req_t in_req;

  assign in_req = cwl_pkg::req_t'(s_tuser);

  // datapath conditions
  always_comb begin
    out_free    = !m_tvalid || m_tready;
    hit         = rd_pend && (rd_data == card_id);
    scan_end    = hit || (!rd_pend && (scan_idx >= card_count));
    table_full  = (card_count >= cwl_pkg::CNT_W'(cwl_pkg::MAX_CARDS));
    pin_ok      = (pin_len == cwl_pkg::LEN_W'(cwl_pkg::PIN_CHARS)) &&
                  (((pin_entry ^ stored_pin) & cwl_pkg::PIN_MASK) == 32'd0);
    streak_inc  = miss_run + 8'd1;
    streak_trig = (streak_inc >= fail_limit);
    lock_level_next = (lock_level != cwl_pkg::LEVEL_MAX) ? lock_level + 8'd1
                                                         : lock_level;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cwl_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          priority case (in_req)
            cwl_pkg::REQ_CHECK: state_next = cwl_pkg::ST_SCAN;
            cwl_pkg::REQ_ADD:   state_next = table_full ? cwl_pkg::ST_EXEC
                                                        : cwl_pkg::ST_SCAN;
            cwl_pkg::REQ_FAIL:  state_next = cwl_pkg::ST_FAIL;
            default:            state_next = cwl_pkg::ST_EXEC;
          endcase
        end
      end
      cwl_pkg::ST_SCAN:      if (scan_end) state_next = cwl_pkg::ST_RESP;
      cwl_pkg::ST_EXEC:      state_next = cwl_pkg::ST_RESP;
      cwl_pkg::ST_FAIL:      state_next = streak_trig ? cwl_pkg::ST_LOCK_WAIT
                                                      : cwl_pkg::ST_RESP;
      cwl_pkg::ST_LOCK_WAIT: state_next = cwl_pkg::ST_LOCK_SET;
      cwl_pkg::ST_LOCK_SET:  state_next = cwl_pkg::ST_RESP;
      cwl_pkg::ST_RESP:      if (out_free) state_next = cwl_pkg::ST_IDLE;
      default:               state_next = cwl_pkg::ST_IDLE;
    endcase
  end

  // state outputs: handshake and card store port
  always_comb begin
    s_tready      = (state == cwl_pkg::ST_IDLE);
    mem_req.re    = (state == cwl_pkg::ST_SCAN) && (scan_idx < card_count);
    mem_req.raddr = scan_idx[cwl_pkg::IDX_W-1:0];
    mem_req.we    = (state == cwl_pkg::ST_SCAN) && scan_end &&
                    (req == cwl_pkg::REQ_ADD) && !hit;
    mem_req.waddr = card_count[cwl_pkg::IDX_W-1:0];
    mem_req.wdata = card_id;
  end

  cwl_card_mem u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  cwl_lock_calc u_lock (
    .clk     (clk),
    .level   (lock_level),
    .base_ms (base_ms),
    .max_ms  (max_ms),
    .lock_ms (lock_ms)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cwl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fail_limit <= cwl_pkg::FAIL_LIMIT_RESET;
      base_ms    <= cwl_pkg::BASE_MS_RESET;
      max_ms     <= cwl_pkg::MAX_MS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cwl_pkg::CFG_FAIL_LIMIT: fail_limit <= cfg_data[7:0];
        cwl_pkg::CFG_BASE_MS:    base_ms    <= cfg_data;
        cwl_pkg::CFG_MAX_MS:     max_ms     <= cfg_data;
        default:                 ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req         <= in_req;
      card_id     <= s_tdata[31:0];
      pin_entry   <= s_tdata[63:32];
      pin_len     <= s_tdata[67:64];
      new_pin     <= s_tdata[99:68];
      new_pin_len <= s_tdata[103:100];
      now_ms      <= s_tdata[135:104];
    end
  end

  // scan counter and read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_pend  <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      scan_idx <= '0;
      rd_pend  <= 1'b0;
    end else if (state == cwl_pkg::ST_SCAN) begin
      rd_pend <= mem_req.re;
      if (mem_req.re) begin
        scan_idx <= scan_idx + cwl_pkg::CNT_W'(1);
      end
    end
  end

  // guard state and result build
  always_ff @(posedge clk) begin
    if (rst) begin
      card_count  <= '0;
      stored_pin  <= cwl_pkg::PIN_RESET;
      miss_run    <= 8'd0;
      lock_level  <= 8'd0;
      deadline    <= 32'd0;
      res_ok      <= 1'b0;
      res_locked  <= 1'b0;
      res_rem     <= 32'd0;
    end else begin
      unique case (state)
        cwl_pkg::ST_IDLE: begin
          res_ok     <= 1'b0;
          res_locked <= 1'b0;
          res_rem    <= 32'd0;
        end
        cwl_pkg::ST_SCAN: begin
          if (scan_end) begin
            if (req == cwl_pkg::REQ_ADD) begin
              res_ok <= 1'b1;
              if (!hit) begin
                card_count <= card_count + cwl_pkg::CNT_W'(1);
              end
            end else begin
              res_ok <= hit;
            end
          end
        end
        cwl_pkg::ST_EXEC: begin
          priority case (req)
            cwl_pkg::REQ_VERIFY: res_ok <= pin_ok;
            cwl_pkg::REQ_SETPIN: begin
              if (pin_ok && (new_pin_len == cwl_pkg::LEN_W'(cwl_pkg::PIN_CHARS))) begin
                stored_pin <= new_pin & cwl_pkg::PIN_MASK;
                res_ok     <= 1'b1;
              end
            end
            cwl_pkg::REQ_CLEAR: begin
              miss_run    <= 8'd0;
              lock_level  <= 8'd0;
              deadline    <= 32'd0;
            end
            cwl_pkg::REQ_QUERY: begin
              if (now_ms >= deadline) begin
                res_ok <= 1'b1;
              end else begin
                res_locked <= 1'b1;
                res_rem    <= deadline - now_ms;
              end
            end
            // add on a full table and the unused code change nothing
            default: ;
          endcase
        end
        cwl_pkg::ST_FAIL: begin
          if (streak_trig) begin
            miss_run    <= 8'd0;
            lock_level  <= lock_level_next;
          end else begin
            miss_run    <= streak_inc;
          end
        end
        cwl_pkg::ST_LOCK_WAIT: ;
        cwl_pkg::ST_LOCK_SET:  deadline <= now_ms + lock_ms;
        cwl_pkg::ST_RESP:      ;
        default:               ;
      endcase
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == cwl_pkg::ST_RESP && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == cwl_pkg::ST_RESP && out_free) begin
      m_tdata <= {1'b0, card_count, res_rem, res_locked, res_ok};
    end
  end

endmodule

@@ rtl/core/cwl_card_mem.sv @@
`timescale 1ns / 1ps
// card whitelist store: one write port, one read port, registered read data
// depends on cwl_pkg for geometry and the port group type

module cwl_card_mem (
  input  logic              clk,
  input  cwl_pkg::mem_req_t mem_req,
  output logic [31:0]       rd_data
);

  logic [31:0] mem [cwl_pkg::MAX_CARDS];

  // write port
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  // read port, registered, updated only on a read
  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rd_data <= mem[mem_req.raddr];
    end
  end

endmodule

@@ rtl/core/cwl_lock_calc.sv @@
`timescale 1ns / 1ps
// lock duration: base shifted left by level-1, saturating at the maximum
// no package dependencies; instanced by the top level

module cwl_lock_calc (
  input  logic        clk,
  input  logic [7:0]  level,
  input  logic [31:0] base_ms,
  input  logic [31:0] max_ms,
  output logic [31:0] lock_ms
);

  logic [7:0]  shift;
  logic [63:0] shifted;

  // shift amount and widened product of base
  always_comb begin
    shift   = level - 8'd1;
    shifted = {32'd0, base_ms} << shift[4:0];
  end

  // registered saturating result
  always_ff @(posedge clk) begin
    if (base_ms == 32'd0) begin
      lock_ms <= 32'd0;
    end else if (shift >= 8'd32) begin
      lock_ms <= max_ms;
    end else if (shifted > {32'd0, max_ms}) begin
      lock_ms <= max_ms;
    end else begin
      lock_ms <= shifted[31:0];
    end
  end

endmodule

@@ rtl/core/cwl_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the credential whitelist with lockout unit
// depends on cwl_pkg; bound to the top level at the end of this file

module cwl_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [cwl_pkg::OUT_DATA_W-1:0] m_tdata
);

  // response field slices
  logic                      rsp_ok, rsp_locked;
  logic [31:0]               rsp_rem;
  logic [cwl_pkg::CNT_W-1:0] rsp_count;

  assign rsp_ok     = m_tdata[0];
  assign rsp_locked = m_tdata[1];
  assign rsp_rem    = m_tdata[33:2];
  assign rsp_count  = m_tdata[38:34];

  // no response is left standing by reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("response valid after reset");

  // a stalled response holds its contents
  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled response changed");

  // one request in flight: a taken request closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");

  // card count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> rsp_count <= cwl_pkg::CNT_W'(cwl_pkg::MAX_CARDS))
    else $error("card count beyond table depth");

  // locked responses carry time left and no ok, others carry none
  a_lock_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (rsp_locked && !rsp_ok && rsp_rem != 32'd0) ||
                 (!rsp_locked && rsp_rem == 32'd0))
    else $error("inconsistent lock fields");

endmodule

bind credential_whitelist_with_lockout_unit cwl_checker u_cwl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
